>>> rtl/core/rnt_pkg.sv
// Shared types and constants for the reference-counted next-hop table.
package rnt_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef enum logic {
		KIND_REF = 1'b0,
		KIND_REL = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] gateway_high;
		logic [63:0] gateway_low;
		logic [15:0] out_port;
		logic [7:0]  release_index;
	} req_t;

	typedef struct packed {
		logic [7:0]  entry_index;
		logic [31:0] remaining_refs;
		logic        newly_created;
		logic [7:0]  live_entries;
		status_t     status;
	} rsp_t;

	typedef struct packed {
		logic [63:0] gateway_high;
		logic [63:0] gateway_low;
		logic [15:0] out_port;
	} key_t;

	typedef struct packed {
		logic key;
		logic cnt;
		logic nxt;
		logic prv;
	} mem_we_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_HIT,
		S_ALLOC,
		S_RECYC,
		S_LINK1,
		S_LINK2,
		S_REL_CHK,
		S_REL_UN1,
		S_REL_UN2,
		S_RESP
	} fsm_t;

endpackage

>>> rtl/core/rnt_store.sv
// Entry storage: key, count and link memories with one shared registered read port.
module rnt_store #(
	parameter int TABLE_ENTRIES = rnt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               rd_en,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
	output rnt_pkg::key_t                      rd_key,
	output logic [31:0]                        rd_cnt,
	output logic [$clog2(TABLE_ENTRIES):0]     rd_nxt,
	output logic [$clog2(TABLE_ENTRIES):0]     rd_prv,
	input  rnt_pkg::mem_we_t                   we,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   kc_addr,
	input  rnt_pkg::key_t                      wr_key,
	input  logic [31:0]                        wr_cnt,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   nxt_addr,
	input  logic [$clog2(TABLE_ENTRIES):0]     wr_nxt,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   prv_addr,
	input  logic [$clog2(TABLE_ENTRIES):0]     wr_prv
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int LW = IDX_W + 1;

	rnt_pkg::key_t    key_mem [TABLE_ENTRIES];
	logic [31:0]      cnt_mem [TABLE_ENTRIES];
	logic [LW-1:0]    nxt_mem [TABLE_ENTRIES];
	logic [LW-1:0]    prv_mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we.key) begin
			key_mem[kc_addr] <= wr_key;
		end
		if (we.cnt) begin
			cnt_mem[kc_addr] <= wr_cnt;
		end
		if (we.nxt) begin
			nxt_mem[nxt_addr] <= wr_nxt;
		end
		if (we.prv) begin
			prv_mem[prv_addr] <= wr_prv;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_cnt <= cnt_mem[rd_addr];
			rd_nxt <= nxt_mem[rd_addr];
			rd_prv <= prv_mem[rd_addr];
		end
	end

endmodule

>>> rtl/core/refcounted_nexthop_table.sv
// Top level: deduplicating next-hop table with reference counts and a recycle list.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------
//   req     | in        | req_valid, req_stall | rnt_pkg::req_t
//   rsp     | out       | rsp_valid, rsp_stall | rnt_pkg::rsp_t
//
// A reference walks the live list, comparing one entry per memory read, one read per cycle;
// it then counts up a hit, reports a full table, or links a recycled or fresh entry on a miss.
// A release decrements a live entry and moves it onto the recycle list when it reaches zero.
// One transaction is in work at a time; req_stall is high until the result is registered.
// Reset empties both lists and clears the live count; the memories need no clearing pass.
// A stalled result holds the block in its final state until rsp_stall falls.
module refcounted_nexthop_table #(
	parameter int TABLE_ENTRIES = rnt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  rnt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rnt_pkg::rsp_t  rsp
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int LW = IDX_W + 1;
	localparam logic [LW-1:0] NO_LINK = '1;

	rnt_pkg::fsm_t    state_q, state_nxt;
	rnt_pkg::req_t    req_q;
	rnt_pkg::rsp_t    res_q, rsp_q;
	logic             rsp_valid_q;
	logic [LW-1:0]    cur_q, steps_q, live_head_q, recyc_q, fresh_q;
	logic [IDX_W-1:0] slot_q;
	logic [7:0]       live_total_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	rnt_pkg::key_t    rd_key;
	logic [31:0]      rd_cnt;
	logic [LW-1:0]    rd_nxt, rd_prv;
	rnt_pkg::mem_we_t we;
	logic [IDX_W-1:0] kc_addr, nxt_addr, prv_addr;
	rnt_pkg::key_t    wr_key;
	logic [31:0]      wr_cnt;
	logic [LW-1:0]    wr_nxt, wr_prv;

	logic             acc, load;
	logic             head_ok, recyc_ok, fresh_ok, nxt_ok, prv_ok;
	logic             key_hit, walk_on, rel_ok_in, rel_live;
	logic [LW-1:0]    steps_inc;
	logic [31:0]      cnt_inc, cnt_dec;
	logic [IDX_W+7:0] rel_wide_in, rel_wide_q, slot_wide;
	logic [LW+7:0]    cur_wide;
	logic [IDX_W-1:0] rel_ix_in, rel_ix_q;
	rnt_pkg::key_t    req_key;

	assign acc = req_valid && (state_q == rnt_pkg::S_IDLE);
	assign load = (state_q == rnt_pkg::S_RESP) && (!rsp_valid_q || !rsp_stall);

	assign head_ok  = 32'(live_head_q) < 32'(TABLE_ENTRIES);
	assign recyc_ok = 32'(recyc_q) < 32'(TABLE_ENTRIES);
	assign fresh_ok = 32'(fresh_q) < 32'(TABLE_ENTRIES);
	assign nxt_ok   = 32'(rd_nxt) < 32'(TABLE_ENTRIES);
	assign prv_ok   = 32'(rd_prv) < 32'(TABLE_ENTRIES);

	assign req_key = '{gateway_high: req_q.gateway_high, gateway_low: req_q.gateway_low,
		out_port: req_q.out_port};
	assign key_hit = (rd_key == req_key);
	assign steps_inc = steps_q + LW'(1);
	assign walk_on = nxt_ok && (32'(steps_inc) < 32'(TABLE_ENTRIES));

	assign cnt_inc = (rd_cnt == rnt_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + 32'd1;
	assign cnt_dec = rd_cnt - 32'd1;

	assign rel_wide_in = {{IDX_W{1'b0}}, req.release_index};
	assign rel_wide_q  = {{IDX_W{1'b0}}, req_q.release_index};
	assign rel_ix_in   = rel_wide_in[IDX_W-1:0];
	assign rel_ix_q    = rel_wide_q[IDX_W-1:0];
	assign slot_wide   = {8'd0, slot_q};
	assign cur_wide    = {8'd0, cur_q};

	assign rel_ok_in = (req.release_index != 8'd0) &&
		(32'(req.release_index) < 32'(TABLE_ENTRIES));
	assign rel_live = (32'(req_q.release_index) < 32'(fresh_q)) && (rd_cnt != 32'd0);

	rnt_store #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_cnt  (rd_cnt),
		.rd_nxt  (rd_nxt),
		.rd_prv  (rd_prv),
		.we      (we),
		.kc_addr (kc_addr),
		.wr_key  (wr_key),
		.wr_cnt  (wr_cnt),
		.nxt_addr(nxt_addr),
		.wr_nxt  (wr_nxt),
		.prv_addr(prv_addr),
		.wr_prv  (wr_prv)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rnt_pkg::S_IDLE: begin
				if (acc) begin
					if (req.kind == rnt_pkg::KIND_REF) begin
						state_nxt = head_ok ? rnt_pkg::S_WALK : rnt_pkg::S_ALLOC;
					end else begin
						state_nxt = rel_ok_in ? rnt_pkg::S_REL_CHK : rnt_pkg::S_RESP;
					end
				end
			end
			rnt_pkg::S_WALK: begin
				if (key_hit) begin
					state_nxt = rnt_pkg::S_HIT;
				end else if (!walk_on) begin
					state_nxt = rnt_pkg::S_ALLOC;
				end
			end
			rnt_pkg::S_HIT: state_nxt = rnt_pkg::S_RESP;
			rnt_pkg::S_ALLOC: begin
				if (recyc_ok) begin
					state_nxt = rnt_pkg::S_RECYC;
				end else if (fresh_ok) begin
					state_nxt = rnt_pkg::S_LINK1;
				end else begin
					state_nxt = rnt_pkg::S_RESP;
				end
			end
			rnt_pkg::S_RECYC: state_nxt = rnt_pkg::S_LINK1;
			rnt_pkg::S_LINK1: state_nxt = rnt_pkg::S_LINK2;
			rnt_pkg::S_LINK2: state_nxt = rnt_pkg::S_RESP;
			rnt_pkg::S_REL_CHK: begin
				if (rel_live && (cnt_dec == 32'd0)) begin
					state_nxt = rnt_pkg::S_REL_UN1;
				end else begin
					state_nxt = rnt_pkg::S_RESP;
				end
			end
			rnt_pkg::S_REL_UN1: state_nxt = rnt_pkg::S_REL_UN2;
			rnt_pkg::S_REL_UN2: state_nxt = rnt_pkg::S_RESP;
			rnt_pkg::S_RESP: begin
				if (load) begin
					state_nxt = rnt_pkg::S_IDLE;
				end
			end
			default: state_nxt = rnt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = cur_q[IDX_W-1:0];
		we       = '0;
		kc_addr  = slot_q;
		wr_key   = req_key;
		wr_cnt   = 32'd1;
		nxt_addr = slot_q;
		wr_nxt   = live_head_q;
		prv_addr = slot_q;
		wr_prv   = NO_LINK;
		case (state_q)
			rnt_pkg::S_IDLE: begin
				if (acc) begin
					if (req.kind == rnt_pkg::KIND_REF) begin
						rd_en   = head_ok;
						rd_addr = live_head_q[IDX_W-1:0];
					end else begin
						rd_en   = rel_ok_in;
						rd_addr = rel_ix_in;
					end
				end
			end
			rnt_pkg::S_WALK: begin
				rd_en   = !key_hit && walk_on;
				rd_addr = rd_nxt[IDX_W-1:0];
			end
			rnt_pkg::S_HIT: begin
				we.cnt  = 1'b1;
				kc_addr = cur_q[IDX_W-1:0];
				wr_cnt  = cnt_inc;
			end
			rnt_pkg::S_ALLOC: begin
				rd_en   = recyc_ok;
				rd_addr = recyc_q[IDX_W-1:0];
			end
			rnt_pkg::S_LINK1: begin
				we.key = 1'b1;
				we.cnt = 1'b1;
				we.nxt = 1'b1;
				we.prv = 1'b1;
			end
			rnt_pkg::S_LINK2: begin
				we.prv   = head_ok;
				prv_addr = live_head_q[IDX_W-1:0];
				wr_prv   = LW'(slot_q);
			end
			rnt_pkg::S_REL_CHK: begin
				we.cnt  = rel_live;
				kc_addr = rel_ix_q;
				wr_cnt  = cnt_dec;
			end
			rnt_pkg::S_REL_UN1: begin
				we.nxt   = prv_ok;
				nxt_addr = rd_prv[IDX_W-1:0];
				wr_nxt   = rd_nxt;
				we.prv   = nxt_ok;
				prv_addr = rd_nxt[IDX_W-1:0];
				wr_prv   = rd_prv;
			end
			rnt_pkg::S_REL_UN2: begin
				we.nxt   = 1'b1;
				nxt_addr = rel_ix_q;
				wr_nxt   = recyc_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rnt_pkg::S_IDLE;
			live_head_q  <= NO_LINK;
			recyc_q      <= NO_LINK;
			fresh_q      <= LW'(1);
			live_total_q <= 8'd0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == rnt_pkg::S_ALLOC && !recyc_ok && fresh_ok) begin
				fresh_q <= fresh_q + LW'(1);
			end
			if (state_q == rnt_pkg::S_RECYC) begin
				recyc_q <= rd_nxt;
			end
			if (state_q == rnt_pkg::S_LINK2) begin
				live_head_q  <= LW'(slot_q);
				live_total_q <= live_total_q + 8'd1;
			end
			if (state_q == rnt_pkg::S_REL_UN1 && !prv_ok) begin
				live_head_q <= rd_nxt;
			end
			if (state_q == rnt_pkg::S_REL_UN2) begin
				recyc_q      <= LW'(rel_ix_q);
				live_total_q <= live_total_q - 8'd1;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rnt_pkg::S_IDLE: begin
				if (acc) begin
					req_q   <= req;
					cur_q   <= live_head_q;
					steps_q <= '0;
					res_q   <= '{entry_index: req.release_index, remaining_refs: 32'd0,
						newly_created: 1'b0, live_entries: live_total_q,
						status: rnt_pkg::ST_BAD};
				end
			end
			rnt_pkg::S_WALK: begin
				if (!key_hit) begin
					cur_q   <= rd_nxt;
					steps_q <= steps_inc;
				end
			end
			rnt_pkg::S_HIT: begin
				res_q <= '{entry_index: cur_wide[7:0], remaining_refs: cnt_inc,
					newly_created: 1'b0, live_entries: live_total_q,
					status: rnt_pkg::ST_OK};
			end
			rnt_pkg::S_ALLOC: begin
				if (recyc_ok) begin
					slot_q <= recyc_q[IDX_W-1:0];
				end else if (fresh_ok) begin
					slot_q <= fresh_q[IDX_W-1:0];
				end else begin
					res_q <= '{entry_index: 8'd0, remaining_refs: 32'd0,
						newly_created: 1'b0, live_entries: live_total_q,
						status: rnt_pkg::ST_FULL};
				end
			end
			rnt_pkg::S_LINK2: begin
				res_q <= '{entry_index: slot_wide[7:0], remaining_refs: 32'd1,
					newly_created: 1'b1, live_entries: live_total_q + 8'd1,
					status: rnt_pkg::ST_OK};
			end
			rnt_pkg::S_REL_CHK: begin
				if (rel_live) begin
					res_q.remaining_refs <= cnt_dec;
					res_q.status         <= rnt_pkg::ST_OK;
				end
			end
			rnt_pkg::S_REL_UN2: begin
				res_q.live_entries <= live_total_q - 8'd1;
			end
			rnt_pkg::S_RESP: begin
				if (load) begin
					rsp_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall = (state_q != rnt_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_fresh_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fresh_q != '0) && (32'(fresh_q) <= 32'(TABLE_ENTRIES)))
		else $error("fresh slot pointer out of range");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == rnt_pkg::ST_FULL) |->
		(rsp.entry_index == 8'd0 && rsp.remaining_refs == 32'd0 && !rsp.newly_created))
		else $error("table-full result carries entry data");

	a_new_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.newly_created) |->
		(rsp.remaining_refs == 32'd1 && rsp.status == rnt_pkg::ST_OK))
		else $error("new entry result without a single reference");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == rnt_pkg::S_RESP))
		else $error("result raised outside the response state");

	a_head_link: assert property (@(posedge clk) disable iff (!arst_n)
		head_ok || (live_head_q == NO_LINK))
		else $error("live list head is neither an entry nor empty");

endmodule

>>> dv/refcounted_nexthop_table_check.sv
`timescale 1ns / 100ps
// Checker for the next-hop table: predicts each response from the accepted requests and compares.
module refcounted_nexthop_table_check (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  rnt_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  rnt_pkg::rsp_t rsp,
	output int            fail_count,
	output int            pending
);

	localparam int ENTRIES = rnt_pkg::TABLE_ENTRIES_DEF;
	localparam logic [8:0] NO_LINK = 9'h1FF;

	logic [63:0] gw_high_mem [ENTRIES];
	logic [63:0] gw_low_mem [ENTRIES];
	logic [15:0] port_mem [ENTRIES];
	logic [31:0] refs_mem [ENTRIES];
	logic        live_mem [ENTRIES];
	logic [8:0]  next_mem [ENTRIES];
	logic [8:0]  prev_mem [ENTRIES];
	logic [8:0]  live_head;
	logic [8:0]  recycle_head;
	logic [8:0]  fresh_slot;
	logic [7:0]  live_total;

	rnt_pkg::rsp_t expected_rsp [$];

	initial begin
		for (int i = 0; i < ENTRIES; i++)
			live_mem[i] = 1'b0;
		live_head = NO_LINK;
		recycle_head = NO_LINK;
		fresh_slot = 9'd1;
		live_total = 8'd0;
		fail_count = 0;
		pending = 0;
	end

	function automatic rnt_pkg::rsp_t predict_entry_rsp(input rnt_pkg::req_t item);
		rnt_pkg::rsp_t res;
		logic [8:0] cur;
		logic [8:0] slot;
		logic [8:0] p;
		logic [8:0] n;
		logic [7:0] idx;
		int steps;
		logic hit;
		res = '0;
		res.status = rnt_pkg::ST_OK;
		if (item.kind == rnt_pkg::KIND_REF) begin
			cur = live_head;
			steps = 0;
			hit = 1'b0;
			while (!hit && cur < ENTRIES && steps < ENTRIES) begin
				if (gw_high_mem[cur[7:0]] == item.gateway_high
						&& gw_low_mem[cur[7:0]] == item.gateway_low
						&& port_mem[cur[7:0]] == item.out_port) begin
					hit = 1'b1;
				end else begin
					cur = next_mem[cur[7:0]];
					steps++;
				end
			end
			if (hit) begin
				if (refs_mem[cur[7:0]] != rnt_pkg::COUNT_MAX)
					refs_mem[cur[7:0]]++;
				res.entry_index = cur[7:0];
				res.remaining_refs = refs_mem[cur[7:0]];
			end else if (recycle_head < ENTRIES || fresh_slot < ENTRIES) begin
				if (recycle_head < ENTRIES) begin
					slot = recycle_head;
					recycle_head = next_mem[slot[7:0]];
				end else begin
					slot = fresh_slot;
					fresh_slot++;
				end
				live_total++;
				refs_mem[slot[7:0]] = 32'd1;
				gw_high_mem[slot[7:0]] = item.gateway_high;
				gw_low_mem[slot[7:0]] = item.gateway_low;
				port_mem[slot[7:0]] = item.out_port;
				live_mem[slot[7:0]] = 1'b1;
				prev_mem[slot[7:0]] = NO_LINK;
				next_mem[slot[7:0]] = live_head;
				if (live_head < ENTRIES)
					prev_mem[live_head[7:0]] = slot;
				live_head = slot;
				res.entry_index = slot[7:0];
				res.remaining_refs = 32'd1;
				res.newly_created = 1'b1;
			end else begin
				res.status = rnt_pkg::ST_FULL;
			end
		end else begin
			idx = item.release_index;
			res.entry_index = idx;
			if (idx == 8'd0 || !live_mem[idx]) begin
				res.status = rnt_pkg::ST_BAD;
			end else begin
				refs_mem[idx]--;
				if (refs_mem[idx] == 32'd0) begin
					p = prev_mem[idx];
					n = next_mem[idx];
					if (p < ENTRIES)
						next_mem[p[7:0]] = n;
					else
						live_head = n;
					if (n < ENTRIES)
						prev_mem[n[7:0]] = p;
					live_mem[idx] = 1'b0;
					next_mem[idx] = recycle_head;
					recycle_head = {1'b0, idx};
					live_total--;
				end
				res.remaining_refs = refs_mem[idx];
			end
		end
		res.live_entries = live_total;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : watch
		rnt_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %0h", $time, rsp);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					check_field("entry_index", 64'(want.entry_index), 64'(rsp.entry_index));
					check_field("remaining_refs", 64'(want.remaining_refs),
						64'(rsp.remaining_refs));
					check_field("newly_created", 64'(want.newly_created),
						64'(rsp.newly_created));
					check_field("live_entries", 64'(want.live_entries), 64'(rsp.live_entries));
					check_field("status", 64'(want.status), 64'(rsp.status));
				end
			end
			if (req_valid && !req_stall)
				expected_rsp.push_back(predict_entry_rsp(req));
			pending = expected_rsp.size();
		end
	end

endmodule

>>> dv/refcounted_nexthop_table_test.sv
`timescale 1ns / 100ps
// Testbench top for the next-hop table: request stimulus, response back-pressure and verdict.
module refcounted_nexthop_table_test;

	localparam int ENTRIES = rnt_pkg::TABLE_ENTRIES_DEF;
	localparam int POOL_SIZE = 16;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int HOLD_CYCLES = 400;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_stall;
	rnt_pkg::req_t req_bus = '0;
	logic          rsp_valid;
	logic          rsp_stall = 1'b0;
	rnt_pkg::rsp_t rsp_bus;
	int            fail_count;
	int            pending;
	int            cycles = 0;
	logic          idle_en = 1'b1;
	int            hold_req = 0;
	int            hold_seen = 0;
	int            hold_left = 0;
	int            burst_left = 0;
	rnt_pkg::key_t key_pool [POOL_SIZE];

	refcounted_nexthop_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_bus),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_bus)
	);

	refcounted_nexthop_table_check response_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req_bus),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp_bus),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// hold off responses: long hold on request, otherwise short random bursts while idle_en is set
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			rsp_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			burst_left = $urandom_range(0, 5);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	function automatic rnt_pkg::key_t random_key();
		rnt_pkg::key_t k;
		k.gateway_high = {$urandom, $urandom};
		k.gateway_low = {$urandom, $urandom};
		k.out_port = 16'($urandom);
		return k;
	endfunction

	function automatic rnt_pkg::req_t ref_item(input rnt_pkg::key_t k);
		rnt_pkg::req_t it;
		it.kind = rnt_pkg::KIND_REF;
		it.gateway_high = k.gateway_high;
		it.gateway_low = k.gateway_low;
		it.out_port = k.out_port;
		it.release_index = 8'($urandom);
		return it;
	endfunction

	function automatic rnt_pkg::req_t release_item(input logic [7:0] idx);
		rnt_pkg::req_t it;
		it.kind = rnt_pkg::KIND_REL;
		it.gateway_high = {$urandom, $urandom};
		it.gateway_low = {$urandom, $urandom};
		it.out_port = 16'($urandom);
		it.release_index = idx;
		return it;
	endfunction

	// neighbors in the pool often differ in a single field
	task automatic refill_pool();
		rnt_pkg::key_t k;
		for (int i = 0; i < POOL_SIZE; i++) begin
			k = random_key();
			if (i > 0 && $urandom_range(0, 1) == 0) begin
				k = key_pool[i - 1];
				case ($urandom_range(0, 2))
					0: k.gateway_high = {$urandom, $urandom};
					1: k.gateway_low = {$urandom, $urandom};
					default: k.out_port = 16'($urandom);
				endcase
			end
			key_pool[i] = k;
		end
	endtask

	function automatic rnt_pkg::req_t random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			return ref_item(key_pool[$urandom_range(0, POOL_SIZE - 1)]);
		if (pick < 55)
			return ref_item(random_key());
		if (pick < 92)
			return release_item(8'($urandom_range(1, 40)));
		return release_item(8'($urandom));
	endfunction

	task automatic send_item(input rnt_pkg::req_t item);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_bus <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		rnt_pkg::key_t k0;
		rnt_pkg::key_t k1;
		rnt_pkg::key_t k;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		k0 = '0;
		k1 = '1;
		send_item(ref_item(k0));
		send_item(ref_item(k1));
		send_item(ref_item(k0));
		k = k0;
		k.out_port = 16'hFFFF;
		send_item(ref_item(k));
		k = k1;
		k.gateway_low = '0;
		send_item(ref_item(k));
		k = k1;
		k.gateway_high = '0;
		send_item(ref_item(k));
		send_item(release_item(8'd0));
		send_item(release_item(8'hFF));
		send_item(release_item(8'd1));
		send_item(release_item(8'd1));
		send_item(release_item(8'd1));
		send_item(release_item(8'd5));
		send_item(release_item(8'd3));
		repeat (4) send_item(ref_item(random_key()));
		send_item(ref_item(k1));
		send_item(release_item(8'd2));
		send_item(release_item(8'd2));

		refill_pool();
		repeat (800) send_item(random_item());

		// hold responses while requests keep coming
		hold_req++;
		repeat (8) send_item(random_item());
		drain();

		// fill the table past capacity, then release each entry index once
		repeat (260) send_item(ref_item(random_key()));
		for (int i = 1; i < ENTRIES; i++)
			send_item(release_item(8'(i)));
		repeat (20) send_item(release_item(8'($urandom_range(1, ENTRIES - 1))));

		idle_en = 1'b0;
		refill_pool();
		repeat (450) send_item(random_item());

		drain();
		repeat (ENTRIES + 10) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
